FILE: sv/timed_setpoint_playback_top_defines.svh
// ----------------------------------------------------------------------------
// Timed setpoint playback assertion macros
// Shared property shapes for the port checker, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_SETPOINT_PLAYBACK_TOP_DEFINES_SVH
`define TIMED_SETPOINT_PLAYBACK_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define TSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Sizes, codes and controller/datapath link types for timed setpoint playback.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // Trajectory sizing
    localparam int MAX_ENTRIES  = 64;
    localparam int COMMAND_BITS = 64;
    localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W       = IDX_W + 1;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int TIME_W   = 32;
    localparam int CMD_IN_W = 64;
    localparam int RIDX_W   = 6;
    localparam int STEP_W   = 16;

    // Configuration port
    localparam int                PADDR_W       = 3;
    localparam int                PDATA_W       = 32;
    localparam logic              REG_TICK_STEP = 1'b0;
    localparam logic [STEP_W-1:0] TICK_STEP_RST = 16'd1000;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] RES_CMD    = 2'd0;
    localparam logic [KIND_W-1:0] RES_ACCEPT = 2'd1;
    localparam logic [KIND_W-1:0] RES_REJECT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic tick;
        logic stop;
        logic scan;
        logic push;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              scan_start;
        logic              scan_done;
        logic              scan_emit;
        logic              out_free;
    } t_dp_sts;

endpackage

FILE: sv/tsp_if.sv
// ----------------------------------------------------------------------------
// tsp_item_if / tsp_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tsp_item_if;
    logic                          valid;
    logic                          ready;
    logic [tsp_pkg::KIND_W-1:0]    kind;
    logic [tsp_pkg::TIME_W-1:0]    entry_time;
    logic [tsp_pkg::CMD_IN_W-1:0]  entry_command;
    logic                          last_entry;

    modport source (output valid, kind, entry_time, entry_command, last_entry,
                    input ready);
    modport sink   (input valid, kind, entry_time, entry_command, last_entry,
                    output ready);
endinterface

interface tsp_result_if;
    logic                          valid;
    logic                          ready;
    logic [tsp_pkg::KIND_W-1:0]    result_kind;
    logic [tsp_pkg::CMD_IN_W-1:0]  command_out;
    logic [tsp_pkg::RIDX_W-1:0]    command_index;
    logic                          finished;

    modport source (output valid, result_kind, command_out, command_index, finished,
                    input ready);
    modport sink   (input valid, result_kind, command_out, command_index, finished,
                    output ready);
endinterface

FILE: sv/tsp_datapath.sv
// ----------------------------------------------------------------------------
// tsp_datapath
// Two-bank trajectory store, load checking, elapsed time, due-entry scan
// and the result output register.
// ----------------------------------------------------------------------------
module tsp_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsp_pkg::t_dp_cmd              i_cmd,
    output tsp_pkg::t_dp_sts              o_sts,
    input  logic [tsp_pkg::STEP_W-1:0]    i_tick_step,
    input  logic [tsp_pkg::KIND_W-1:0]    i_kind,
    input  logic [tsp_pkg::TIME_W-1:0]    i_entry_time,
    input  logic [tsp_pkg::CMD_IN_W-1:0]  i_entry_command,
    input  logic                          i_last_entry,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tsp_pkg::KIND_W-1:0]    o_result_kind,
    output logic [tsp_pkg::CMD_IN_W-1:0]  o_command_out,
    output logic [tsp_pkg::RIDX_W-1:0]    o_command_index,
    output logic                          o_finished
);
    import tsp_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    // Trajectory stores, bank in the top address bit
    logic [TIME_W-1:0]       time_mem [0:DEPTH-1];
    logic [COMMAND_BITS-1:0] cmd_mem  [0:DEPTH-1];
    logic [TIME_W-1:0]       r_rd_time;
    logic [COMMAND_BITS-1:0] r_rd_cmd;
    logic [ADDR_W-1:0]       wr_addr, rd_addr;
    logic                    mem_we;

    // Captured item
    logic [KIND_W-1:0]       r_kind;
    logic [TIME_W-1:0]       r_time;
    logic [COMMAND_BITS-1:0] r_cmd_in;
    logic                    r_last;

    // Control state
    logic              r_active_bank, n_active_bank;
    logic [CNT_W-1:0]  r_load_count,  n_load_count;
    logic [TIME_W-1:0] r_prev_time,   n_prev_time;
    logic              r_load_bad,    n_load_bad;
    logic [CNT_W-1:0]  r_play_len,    n_play_len;
    logic [CNT_W-1:0]  r_play_idx,    n_play_idx;
    logic [TIME_W-1:0] r_elapsed,     n_elapsed;
    logic              r_running,     n_running;
    logic              r_any,         n_any;
    logic              r_out_valid,   n_out_valid;

    // Scan and result payload
    logic [CNT_W-1:0]        r_next,     n_next;
    logic [COMMAND_BITS-1:0] r_hit_cmd,  n_hit_cmd;
    logic [KIND_W-1:0]       r_res_kind, n_res_kind;
    logic [COMMAND_BITS-1:0] r_res_cmd,  n_res_cmd;
    logic [RIDX_W-1:0]       r_res_idx,  n_res_idx;
    logic                    r_res_fin,  n_res_fin;
    logic [KIND_W-1:0]       r_out_kind;
    logic [COMMAND_BITS-1:0] r_out_cmd;
    logic [RIDX_W-1:0]       r_out_idx;
    logic                    r_out_fin;

    // Combinational helpers
    logic              overflow, decreasing, bad_now;
    logic [CNT_W-1:0]  cnt_inc, next_inc, final_idx;
    logic [TIME_W:0]   step_sum;
    logic              hit, more, scan_done, scan_emit, fin;

    assign overflow   = (r_load_count >= CNT_W'(MAX_ENTRIES));
    assign decreasing = (r_load_count != '0) && (r_time < r_prev_time);
    assign bad_now    = r_load_bad || overflow || decreasing;
    assign cnt_inc    = r_load_count + CNT_W'(1);
    assign step_sum   = {1'b0, r_elapsed} + (TIME_W + 1)'(i_tick_step);

    // One compare per cycle against the entry read last cycle
    assign hit       = (r_rd_time <= r_elapsed);
    assign next_inc  = r_next + CNT_W'(1);
    assign more      = (next_inc < r_play_len);
    assign scan_done = !(hit && more);
    assign scan_emit = hit || r_any;
    assign final_idx = hit ? next_inc : r_next;
    assign fin       = (final_idx >= r_play_len);

    assign mem_we  = i_cmd.load && !overflow;
    assign wr_addr = {~r_active_bank, r_load_count[IDX_W-1:0]};
    assign rd_addr = i_cmd.scan ? {r_active_bank, next_inc[IDX_W-1:0]}
                                : {r_active_bank, r_play_idx[IDX_W-1:0]};

    // Status to the controller
    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.last       = r_last;
        o_sts.scan_start = r_running && (r_play_idx < r_play_len);
        o_sts.scan_done  = scan_done;
        o_sts.scan_emit  = scan_emit;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            time_mem[wr_addr] <= r_time;
            cmd_mem[wr_addr]  <= r_cmd_in;
        end
        r_rd_time <= time_mem[rd_addr];
        r_rd_cmd  <= cmd_mem[rd_addr];
    end

    // Next-state logic for load, tick, stop, scan and output
    always_comb begin
        n_active_bank = r_active_bank;
        n_load_count  = r_load_count;
        n_prev_time   = r_prev_time;
        n_load_bad    = r_load_bad;
        n_play_len    = r_play_len;
        n_play_idx    = r_play_idx;
        n_elapsed     = r_elapsed;
        n_running     = r_running;
        n_any         = r_any;
        n_next        = r_next;
        n_hit_cmd     = r_hit_cmd;
        n_res_kind    = r_res_kind;
        n_res_cmd     = r_res_cmd;
        n_res_idx     = r_res_idx;
        n_res_fin     = r_res_fin;
        n_out_valid   = r_out_valid;

        // Load entry into the shadow bank
        if (i_cmd.load) begin
            if (!overflow) begin
                n_load_count = cnt_inc;
                n_prev_time  = r_time;
            end
            n_load_bad = bad_now;
            if (r_last) begin
                if (!bad_now) begin
                    n_active_bank = ~r_active_bank;
                    n_play_len    = overflow ? r_load_count : cnt_inc;
                    n_play_idx    = '0;
                    n_elapsed     = '0;
                    n_running     = 1'b1;
                end
                n_load_count = '0;
                n_prev_time  = '0;
                n_load_bad   = 1'b0;
                n_res_kind   = bad_now ? RES_REJECT : RES_ACCEPT;
                n_res_cmd    = '0;
                n_res_idx    = '0;
                n_res_fin    = 1'b0;
            end
        end

        // Tick: saturating time advance, scan starts at play index
        if (i_cmd.tick) begin
            n_elapsed = step_sum[TIME_W] ? '1 : step_sum[TIME_W-1:0];
            n_next    = r_play_idx;
            n_any     = 1'b0;
        end

        if (i_cmd.stop) begin
            n_running = 1'b0;
        end

        // Skip due entries, keep the latest command
        if (i_cmd.scan) begin
            if (hit) begin
                n_next    = next_inc;
                n_any     = 1'b1;
                n_hit_cmd = r_rd_cmd;
            end
            if (scan_done && scan_emit) begin
                n_play_idx = final_idx;
                if (fin) begin
                    n_running = 1'b0;
                end
                n_res_kind = RES_CMD;
                n_res_cmd  = hit ? r_rd_cmd : r_hit_cmd;
                n_res_idx  = RIDX_W'(final_idx - CNT_W'(1));
                n_res_fin  = fin;
            end
        end

        // Output register
        if (i_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bank <= 1'b0;
            r_load_count  <= '0;
            r_prev_time   <= '0;
            r_load_bad    <= 1'b0;
            r_play_len    <= '0;
            r_play_idx    <= '0;
            r_elapsed     <= '0;
            r_running     <= 1'b0;
            r_any         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_active_bank <= n_active_bank;
            r_load_count  <= n_load_count;
            r_prev_time   <= n_prev_time;
            r_load_bad    <= n_load_bad;
            r_play_len    <= n_play_len;
            r_play_idx    <= n_play_idx;
            r_elapsed     <= n_elapsed;
            r_running     <= n_running;
            r_any         <= n_any;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_time   <= i_entry_time;
            r_cmd_in <= i_entry_command[COMMAND_BITS-1:0];
            r_last   <= i_last_entry;
        end
        r_next     <= n_next;
        r_hit_cmd  <= n_hit_cmd;
        r_res_kind <= n_res_kind;
        r_res_cmd  <= n_res_cmd;
        r_res_idx  <= n_res_idx;
        r_res_fin  <= n_res_fin;
        if (i_cmd.push) begin
            r_out_kind <= r_res_kind;
            r_out_cmd  <= r_res_cmd;
            r_out_idx  <= r_res_idx;
            r_out_fin  <= r_res_fin;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_command_out   = CMD_IN_W'(r_out_cmd);
    assign o_command_index = r_out_idx;
    assign o_finished      = r_out_fin;

endmodule

FILE: sv/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// tsp_ctrl
// Sequencer: takes one item, runs it through the datapath, hands off the
// result, if there is one.
// ----------------------------------------------------------------------------
module tsp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  tsp_pkg::t_dp_sts i_sts,
    output tsp_pkg::t_dp_cmd o_cmd
);
    import tsp_pkg::*;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_sts.kind)
                    KIND_LOAD: n_state = i_sts.last ? ST_EMIT : ST_IDLE;
                    KIND_TICK: n_state = i_sts.scan_start ? ST_SCAN : ST_IDLE;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.scan_emit ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_item_ready  = 1'b1;
                o_cmd.capture = i_item_valid;
            end
            ST_EXEC: begin
                case (i_sts.kind)
                    KIND_LOAD: o_cmd.load = 1'b1;
                    KIND_TICK: o_cmd.tick = 1'b1;
                    KIND_STOP: o_cmd.stop = 1'b1;
                    default: ;
                endcase
            end
            ST_SCAN: o_cmd.scan = 1'b1;
            ST_EMIT: o_cmd.push = i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/timed_setpoint_playback_top.sv
// ----------------------------------------------------------------------------
// timed_setpoint_playback_top
// Sequence: a final load entry passes the exec and emit states; a tick passes
//   exec, then scan while entries are left, then emit when a command is due.
// Throughput: one transaction at a time; the scan makes one compare per cycle
//   over the time store's single read port; a stalled result holds input off.
// Reset: synchronous, active low; the trajectory stores are not cleared
//   and hold undefined data until a load writes them.
// ----------------------------------------------------------------------------
module timed_setpoint_playback_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tsp_item_if.sink                      i_item,
    tsp_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsp_pkg::PADDR_W-1:0]   paddr,
    input  logic [tsp_pkg::PDATA_W-1:0]   pwdata,
    output logic [tsp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tsp_pkg::*;

    logic [STEP_W-1:0] r_tick_step;
    logic              cfg_wr;
    logic              item_ready;
    t_dp_cmd           dp_cmd;
    t_dp_sts           dp_sts;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TICK_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= TICK_STEP_RST;
        end else if (cfg_wr) begin
            r_tick_step <= pwdata[STEP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TICK_STEP) ? PDATA_W'(r_tick_step) : '0;

    assign i_item.ready = item_ready;

    tsp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (item_ready),
        .i_sts        (dp_sts),
        .o_cmd        (dp_cmd)
    );

    tsp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_tick_step     (r_tick_step),
        .i_kind          (i_item.kind),
        .i_entry_time    (i_item.entry_time),
        .i_entry_command (i_item.entry_command),
        .i_last_entry    (i_item.last_entry),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_result_kind   (o_result.result_kind),
        .o_command_out   (o_result.command_out),
        .o_command_index (o_result.command_index),
        .o_finished      (o_result.finished)
    );

endmodule

FILE: sv/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks for timed setpoint playback, bound to the top level.
// ----------------------------------------------------------------------------
`include "timed_setpoint_playback_top_defines.svh"

module tsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_item_valid,
    input logic                          i_item_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [tsp_pkg::KIND_W-1:0]    i_res_kind,
    input logic [tsp_pkg::CMD_IN_W-1:0]  i_res_cmd,
    input logic [tsp_pkg::RIDX_W-1:0]    i_res_idx,
    input logic                          i_res_fin
);
    import tsp_pkg::*;

    logic                                    res_stalled;
    logic [KIND_W+CMD_IN_W+RIDX_W:0]         res_payload;
    logic                                    item_taken;
    logic                                    load_res;
    logic                                    cmd_fields_zero;

    assign res_stalled     = i_res_valid && !i_res_ready;
    assign res_payload     = {i_res_kind, i_res_cmd, i_res_idx, i_res_fin};
    assign item_taken      = i_item_valid && i_item_ready;
    assign load_res        = i_res_valid && (i_res_kind != RES_CMD);
    assign cmd_fields_zero = (i_res_cmd == '0) && (i_res_idx == '0) && !i_res_fin;

    // A stalled result transaction stays offered
    `TSP_ASSERT_NEXT(a_res_hold, res_stalled, i_res_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `TSP_ASSERT_NEXT(a_res_stable, res_stalled, $stable(res_payload), "result payload changed")

    // One item at a time: no accept in the cycle after an accept
    `TSP_ASSERT_NEXT(a_item_busy, item_taken, !i_item_ready, "input ready after accepted item")

    // Load results carry an empty command payload
    `TSP_ASSERT_SAME(a_load_res_zero, load_res, cmd_fields_zero, "load result with command fields")

endmodule

bind timed_setpoint_playback_top tsp_checker u_tsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_valid (i_item.valid),
    .i_item_ready (i_item.ready),
    .i_res_valid  (o_result.valid),
    .i_res_ready  (o_result.ready),
    .i_res_kind   (o_result.result_kind),
    .i_res_cmd    (o_result.command_out),
    .i_res_idx    (o_result.command_index),
    .i_res_fin    (o_result.finished)
);

FILE: sim/timed_setpoint_playback_top_tb.sv
// ----------------------------------------------------------------------------
// timed_setpoint_playback_top_tb
// Self-checking bench for the timed setpoint playback block. Items go in over
// the valid/ready item channel, and the tick step is set over the APB port.
// A scoreboard class tracks the trajectory banks, the load in progress and
// the playback timer, and predicts every load verdict and emitted command.
// A short directed run covers the corner cases. It is followed by random
// trajectories under several tick steps, with random stalls on both channels.
// ----------------------------------------------------------------------------
module timed_setpoint_playback_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsp_pkg::*;

    localparam logic [KIND_W-1:0]  KIND_UNUSED    = 2'd3;
    localparam logic [PADDR_W-1:0] TICK_STEP_ADDR = PADDR_W'(4 * REG_TICK_STEP);
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR  = TICK_STEP_ADDR + PADDR_W'(4);
    localparam int unsigned        SETTLE_CYCLES  = MAX_ENTRIES + 8;
    localparam int unsigned        CYCLE_LIMIT    = 4_000_000;
    localparam int unsigned        PHASE_ITEMS    = 200;

    // Trajectory player prediction and the queue of results still to come
    class playback_scoreboard;
        typedef struct {
            logic [KIND_W-1:0]   kind;
            logic [CMD_IN_W-1:0] command;
            logic [RIDX_W-1:0]   index;
            logic                finished;
        } t_emitted;

        logic [TIME_W-1:0]   time_mem [2*MAX_ENTRIES];
        logic [CMD_IN_W-1:0] cmd_mem  [2*MAX_ENTRIES];
        bit                  bank;
        int unsigned         fill;
        logic [TIME_W-1:0]   prev_time;
        bit                  fill_bad;
        int unsigned         length;
        int unsigned         cursor;
        logic [TIME_W-1:0]   elapsed;
        bit                  playing;
        logic [STEP_W-1:0]   tick_step;
        t_emitted            awaited [$];
        int unsigned         errors;

        function new();
            foreach (time_mem[i]) begin
                time_mem[i] = '0;
                cmd_mem[i]  = '0;
            end
            bank      = 1'b0;
            fill      = 0;
            prev_time = '0;
            fill_bad  = 1'b0;
            length    = 0;
            cursor    = 0;
            elapsed   = '0;
            playing   = 1'b0;
            tick_step = TICK_STEP_RST;
            errors    = 0;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // Called once per accepted item transaction
        function void apply_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] at_us,
                                 input logic [CMD_IN_W-1:0] command, input logic last);
            t_emitted    res;
            bit          shadow;
            bit          accepted;
            int unsigned slot;
            int unsigned base;
            int unsigned nxt;
            logic [TIME_W:0] sum;

            res.command  = '0;
            res.index    = '0;
            res.finished = 1'b0;
            case (kind)
                KIND_LOAD: begin
                    shadow = ~bank;
                    // a full shadow bank drops the entry and spoils the load
                    if (fill >= MAX_ENTRIES) begin
                        fill_bad = 1'b1;
                    end else begin
                        slot = int'(shadow) * MAX_ENTRIES + fill;
                        if (fill > 0 && at_us < prev_time)
                            fill_bad = 1'b1;
                        time_mem[slot] = at_us;
                        cmd_mem[slot]  = command;
                        fill++;
                        prev_time = at_us;
                    end
                    if (last) begin
                        accepted = !fill_bad;
                        if (accepted) begin
                            bank    = shadow;
                            length  = fill;
                            cursor  = 0;
                            elapsed = '0;
                            playing = 1'b1;
                        end
                        fill      = 0;
                        prev_time = '0;
                        fill_bad  = 1'b0;
                        res.kind  = accepted ? RES_ACCEPT : RES_REJECT;
                        awaited.push_back(res);
                    end
                end
                KIND_TICK: begin
                    // elapsed time saturates instead of wrapping
                    sum     = {1'b0, elapsed} + (TIME_W + 1)'(tick_step);
                    elapsed = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    if (playing) begin
                        base = int'(bank) * MAX_ENTRIES;
                        nxt  = cursor;
                        while (nxt < length && nxt < MAX_ENTRIES && time_mem[base + nxt] <= elapsed)
                            nxt++;
                        if (nxt != cursor) begin
                            cursor       = nxt;
                            res.kind     = RES_CMD;
                            res.command  = cmd_mem[base + nxt - 1];
                            res.index    = RIDX_W'(nxt - 1);
                            res.finished = (nxt >= length);
                            if (res.finished)
                                playing = 1'b0;
                            awaited.push_back(res);
                        end
                    end
                end
                KIND_STOP: begin
                    playing = 1'b0;
                end
                default: ;
            endcase
        endfunction

        // Called once per accepted result transaction
        function void check_result(input logic [KIND_W-1:0] kind, input logic [CMD_IN_W-1:0] command,
                                   input logic [RIDX_W-1:0] index, input logic finished);
            t_emitted exp;

            if (awaited.size() == 0) begin
                $error("unexpected result: result_kind %0d command_out %h", kind, command);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (kind !== exp.kind) begin
                $error("result_kind: expected %0d, got %0d", exp.kind, kind);
                errors++;
            end
            if (command !== exp.command) begin
                $error("command_out: expected %h, got %h", exp.command, command);
                errors++;
            end
            if (index !== exp.index) begin
                $error("command_index: expected %0d, got %0d", exp.index, index);
                errors++;
            end
            if (finished !== exp.finished) begin
                $error("finished: expected %0b, got %0b", exp.finished, finished);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    tsp_item_if   item_ch ();
    tsp_result_if result_ch ();

    playback_scoreboard board = new();

    bit          steady_flow = 1'b0;
    int unsigned step_us_now = TICK_STEP_RST;
    int unsigned items_sent  = 0;
    int unsigned cycles      = 0;

    timed_setpoint_playback_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        result_ch.ready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            board.check_result(result_ch.result_kind, result_ch.command_out,
                               result_ch.command_index, result_ch.finished);
    end

    function automatic logic [CMD_IN_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 6);
        else if (roll < 97)
            return $urandom_range(7, 20);
        return $urandom_range(21, MAX_ENTRIES);
    endfunction

    // One item transaction; valid stays high on return so items can go back to back
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] at_us,
                             input logic [CMD_IN_W-1:0] command, input logic last);
        if (!steady_flow && $urandom_range(0, 99) < 13) begin
            item_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < 40);
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= kind;
        item_ch.entry_time    <= at_us;
        item_ch.entry_command <= command;
        item_ch.last_entry    <= last;
        do @(posedge i_clk); while (!item_ch.ready);
        board.apply_item(kind, at_us, command, last);
        if (kind != KIND_UNUSED)
            items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, $urandom, rand_word(), 1'($urandom));
    endtask

    // Hold off new items until every predicted result is out and the block is quiet
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Whole trajectory load; misorder puts one entry earlier than its predecessor
    task automatic send_trajectory(input int unsigned len, input int unsigned spread,
                                   input bit misorder);
        logic [TIME_W-1:0] at_us;
        int unsigned       flaw_at;
        at_us   = misorder ? $urandom_range(1, spread + 1) : $urandom_range(0, spread);
        flaw_at = (len > 1) ? $urandom_range(1, len - 1) : 0;
        for (int unsigned k = 0; k < len; k++) begin
            if (k > 0) begin
                if (misorder && k == flaw_at)
                    at_us = $urandom_range(0, at_us - 1);
                else
                    at_us = at_us + $urandom_range(0, spread);
            end
            send_item(KIND_LOAD, at_us, rand_word(), k == len - 1);
        end
    endtask

    // APB setup and access; select stays up on return
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [STEP_W-1:0] value, output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
    endtask

    // Optional register write, then a read-back of the tick step
    task automatic configure_step(input bit do_write, input logic [PADDR_W-1:0] addr,
                                  input logic [STEP_W-1:0] value);
        logic [PDATA_W-1:0] rdata;
        drain();
        if (do_write) begin
            apb_access(1'b1, addr, value, rdata);
            if (addr == TICK_STEP_ADDR) begin
                board.tick_step = value;
                step_us_now     = value;
            end
        end
        apb_access(1'b0, TICK_STEP_ADDR, 16'($urandom), rdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rdata[STEP_W-1:0] !== board.tick_step) begin
            $error("tick_step_us: expected %0d, got %0d", board.tick_step, rdata[STEP_W-1:0]);
            board.errors++;
        end
    endtask

    // Mostly well-formed loads and ticks, with some broken loads and noise
    task automatic random_phase(input int unsigned goal);
        int unsigned start;
        int unsigned roll;
        int unsigned spread;
        start  = items_sent;
        spread = 2 * step_us_now + 1;
        while (items_sent - start < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 32)
                send_trajectory(pick_length(), spread, 1'b0);
            else if (roll < 37)
                send_trajectory(pick_length() + 1, spread, 1'b1);
            else if (roll < 85)
                repeat ($urandom_range(1, 6)) send_tick();
            else if (roll < 89)
                send_item(KIND_STOP, $urandom, rand_word(), 1'($urandom));
            else if (roll < 91)
                send_item(KIND_UNUSED, $urandom, rand_word(), 1'($urandom));
            else if (roll < 98)
                send_item(2'($urandom), $urandom, rand_word(), 1'($urandom));
            else
                drain();
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n               = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.kind          = KIND_LOAD;
        item_ch.entry_time    = '0;
        item_ch.entry_command = '0;
        item_ch.last_entry    = 1'b0;
        result_ch.ready       = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the tick step
        configure_step(1'b0, TICK_STEP_ADDR, '0);

        // idle tick, idle stop, unused kind
        send_tick();
        send_item(KIND_STOP, '0, '0, 1'b0);
        send_item(KIND_UNUSED, '1, '1, 1'b1);
        // equal times accepted; first tick skips two entries, second finishes
        send_item(KIND_LOAD, '0, '1, 1'b0);
        send_item(KIND_LOAD, '0, '0, 1'b0);
        send_item(KIND_LOAD, 32'd1500, rand_word(), 1'b1);
        send_tick();
        send_tick();
        send_tick();
        // decreasing time rejected
        send_item(KIND_LOAD, 32'd100, rand_word(), 1'b0);
        send_item(KIND_LOAD, 32'd50, rand_word(), 1'b1);
        // bad load during playback leaves the old trajectory running, then stop
        send_item(KIND_LOAD, '0, rand_word(), 1'b0);
        send_item(KIND_LOAD, 32'd5000, rand_word(), 1'b1);
        send_tick();
        send_item(KIND_LOAD, 32'd7, rand_word(), 1'b0);
        send_item(KIND_LOAD, 32'd3, rand_word(), 1'b1);
        send_tick();
        send_item(KIND_STOP, $urandom, rand_word(), 1'b1);
        send_tick();

        // zero step: due entries still come out, later ones never do
        configure_step(1'b1, TICK_STEP_ADDR, 16'd0);
        send_item(KIND_LOAD, '0, rand_word(), 1'b0);
        send_item(KIND_LOAD, '0, rand_word(), 1'b0);
        send_item(KIND_LOAD, 32'd1, rand_word(), 1'b1);
        send_tick();
        send_tick();
        send_item(KIND_STOP, '0, '0, 1'b0);

        // write to an unmapped register is dropped
        configure_step(1'b1, UNMAPPED_ADDR, 16'hBEEF);

        // smallest step, plus a count overflow and a full bank skipped in one tick
        configure_step(1'b1, TICK_STEP_ADDR, 16'd1);
        send_trajectory(MAX_ENTRIES + 1, 3, 1'b0);
        send_trajectory(MAX_ENTRIES, 0, 1'b0);
        send_tick();
        random_phase(PHASE_ITEMS);

        configure_step(1'b1, TICK_STEP_ADDR, 16'd65535);
        random_phase(PHASE_ITEMS);

        // a long stretch with no stalls on either side
        configure_step(1'b1, TICK_STEP_ADDR, TICK_STEP_RST);
        steady_flow = 1'b1;
        random_phase(PHASE_ITEMS);
        steady_flow = 1'b0;

        configure_step(1'b1, TICK_STEP_ADDR, 16'($urandom_range(1, 65535)));
        random_phase(PHASE_ITEMS);

        drain();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: timed_setpoint_playback_top.f
+incdir+sv
sv/tsp_pkg.sv
sv/tsp_if.sv
sv/tsp_datapath.sv
sv/tsp_ctrl.sv
sv/timed_setpoint_playback_top.sv
sv/tsp_checker.sv
sim/timed_setpoint_playback_top_tb.sv
